@@ hdl/ffa_pkg.sv @@
// ffa_pkg: shared types, codes and defaults for the first-fit free list allocator
// no dependencies; used by every file in hdl/

package ffa_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int ADDR_W            = 32;
	localparam int CNT_W             = 7;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_LOST  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_FIND,
		S_DEC,
		S_UPD
	} state_t;

	// contents of one table cell
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] len;
	} cell_data_t;

	// request values broadcast to all cells
	typedef struct packed {
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] addr_end;
	} cell_key_t;

	// per-cell compare results
	typedef struct packed {
		logic fit;
		logic gt;
		logic endm;
		logic stm;
	} cell_flags_t;

	// update command broadcast to all cells
	typedef struct packed {
		logic              load;
		logic              shl;
		logic              shr;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] len;
	} cell_cmd_t;

	// bookkeeping decided for the final step
	typedef struct packed {
		status_t status;
		logic    inc;
		logic    dec;
		logic    add;
		logic    sub;
		logic    drop;
	} upd_ctl_t;

endpackage

@@ hdl/ffa_cell.sv @@
// ffa_cell: one entry of the free region table with its local compares
// depends on ffa_pkg

module ffa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ffa_pkg::cell_key_t  key,
	input  ffa_pkg::cell_cmd_t  cmd,
	input  logic                tgt,
	input  logic                shl_sel,
	input  logic                shr_sel,
	input  ffa_pkg::cell_data_t left,
	input  ffa_pkg::cell_data_t right,
	output ffa_pkg::cell_data_t data,
	output ffa_pkg::cell_flags_t flags
);

	logic                      valid_q;
	logic [ffa_pkg::ADDR_W-1:0] start_q;
	logic [ffa_pkg::ADDR_W-1:0] len_q;
	logic [ffa_pkg::ADDR_W-1:0] end_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load && tgt) begin
			valid_q <= 1'b1;
		end else if (cmd.shl && shl_sel) begin
			valid_q <= right.valid;
		end else if (cmd.shr && shr_sel) begin
			valid_q <= left.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && tgt) begin
			start_q <= cmd.start;
			len_q   <= cmd.len;
		end else if (cmd.shl && shl_sel) begin
			start_q <= right.start;
			len_q   <= right.len;
		end else if (cmd.shr && shr_sel) begin
			start_q <= left.start;
			len_q   <= left.len;
		end
	end

	// end of region wraps at 32 bits
	assign end_w = start_q + len_q;

	always_comb begin
		data.valid = valid_q;
		data.start = start_q;
		data.len   = len_q;
		flags.fit  = valid_q && (len_q >= key.size);
		flags.gt   = valid_q && (start_q > key.addr);
		flags.endm = (end_w == key.addr);
		flags.stm  = (start_q == key.addr_end);
	end

endmodule

@@ hdl/first_fit_free_list_allocator.sv @@
// first_fit_free_list_allocator: top level, sequencer and row of ffa_cell entries
// depends on ffa_pkg and ffa_cell
//
// Usage:
//  - input channel (in_valid/in_ready) takes one word: mode, region_addr, region_size.
//    mode 0 allocates region_size bytes first-fit, mode 1 releases a region and
//    merges it with exactly adjacent neighbors.
//  - output channel (out_valid/out_ready) gives one word per input word: status,
//    granted_addr and the running totals after the operation.
//  - one word is processed at a time: compare in every cell, first-match search
//    over the compare vector, decode, then an update of the cell row in which
//    cells shift to a neighbor to insert or remove an entry.
//  - the result is loaded into the output register as the update step completes;
//    a new word is taken only once the block is back in idle, so each word runs
//    through the four-step sequence through the cell row before the next is taken.
//  - a stalled receiver holds the block in its update step until the output
//    register is free; the result word stays stable while out_valid is high and out_ready is low.
//  - reset empties the table (all cell valid bits clear) and clears the counters;
//    there is no clearing pass, the block is ready right after reset.
//  - a release with a full table and no merge is dropped and counted in lost_count
//    and lost_bytes, both saturating.

module first_fit_free_list_allocator #(
	parameter int TABLE_ENTRIES = ffa_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [ffa_pkg::ADDR_W-1:0]  region_addr,
	input  logic [ffa_pkg::ADDR_W-1:0]  region_size,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [ffa_pkg::ADDR_W-1:0]  granted_addr,
	output logic [ffa_pkg::ADDR_W-1:0]  total_free,
	output logic [ffa_pkg::CNT_W-1:0]   entry_count,
	output logic [ffa_pkg::CNT_W-1:0]   peak_entries,
	output logic [ffa_pkg::ADDR_W-1:0]  lost_count,
	output logic [ffa_pkg::ADDR_W-1:0]  lost_bytes
);

	localparam int N  = TABLE_ENTRIES;
	localparam int UW = $clog2(TABLE_ENTRIES + 1);
	localparam int AW = ffa_pkg::ADDR_W;
	localparam int CW = ffa_pkg::CNT_W;

	ffa_pkg::state_t state_q, state_d;

	// request registers
	logic          mode_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] size_q;
	logic [AW-1:0] addr_end_q;

	// cell row
	ffa_pkg::cell_key_t   key;
	ffa_pkg::cell_cmd_t   cmd_q, cell_cmd;
	ffa_pkg::cell_data_t  data   [N];
	ffa_pkg::cell_data_t  left_d [N];
	ffa_pkg::cell_data_t  right_d[N];
	ffa_pkg::cell_flags_t flags  [N];
	logic [N-1:0]         tgt_q;
	logic [N-1:0]         shr_mask;

	// compare vectors, stage 1
	logic [N-1:0] fit_v, gt_v, endm_v, stm_v, vld_v;
	logic [N-1:0] fit_s1, gt_s1, endm_s1, stm_s1, vld_s1;

	// first-match search, stage 2
	logic [N:0]   cand, cand_m1;
	logic [N:0]   koh_s2;
	logic [N-1:0] ge_s2;

	// decode
	logic [AW-1:0] sel_start, sel_len, prv_start, prv_len;
	logic [AW-1:0] alloc_start, alloc_len, merge_len;
	logic          prv_match, nxt_match, full;
	ffa_pkg::cell_cmd_t dec_cmd;
	ffa_pkg::upd_ctl_t  dec_ctl, ctl_q;
	logic [N-1:0]       dec_tgt;
	logic [AW-1:0]      dec_granted, granted_q;

	// bookkeeping
	logic [UW-1:0] used_q, peak_q, used_nx;
	logic [AW-1:0] total_q, total_nx;
	logic [AW-1:0] lost_cnt_q, lost_b_q, lost_cnt_nx, lost_b_nx;
	logic [AW:0]   lost_b_sum;
	logic          upd_go;

	// output register
	logic              out_valid_q;
	ffa_pkg::status_t  out_status_q;
	logic [AW-1:0]     out_granted_q, out_total_q, out_lost_cnt_q, out_lost_b_q;
	logic [CW-1:0]     out_count_q, out_peak_q;

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		upd_go   = 1'b0;
		case (state_q)
			ffa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ffa_pkg::S_CMP;
				end
			end
			ffa_pkg::S_CMP:  state_d = ffa_pkg::S_FIND;
			ffa_pkg::S_FIND: state_d = ffa_pkg::S_DEC;
			ffa_pkg::S_DEC:  state_d = ffa_pkg::S_UPD;
			ffa_pkg::S_UPD: begin
				// wait for the output register to free up
				upd_go = !out_valid_q || out_ready;
				if (upd_go) begin
					state_d = ffa_pkg::S_IDLE;
				end
			end
			default: state_d = ffa_pkg::S_IDLE;
		endcase
	end

	// capture request; end address wraps at 32 bits
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q     <= mode;
			addr_q     <= region_addr;
			size_q     <= region_size;
			addr_end_q <= region_addr + region_size;
		end
	end

	// ---------------------------------------------------------------- cell row
	assign key.size     = size_q;
	assign key.addr     = addr_q;
	assign key.addr_end = addr_end_q;

	// gate the decoded command to the update cycle
	always_comb begin
		cell_cmd      = cmd_q;
		cell_cmd.load = cmd_q.load && upd_go;
		cell_cmd.shl  = cmd_q.shl && upd_go;
		cell_cmd.shr  = cmd_q.shr && upd_go;
	end

	// cells after the chosen one take their left neighbor on insert
	assign shr_mask = ge_s2 & ~koh_s2[N-1:0];

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_d[i] = '0;
		end else begin : g_left
			assign left_d[i] = data[i-1];
		end
		if (i == N - 1) begin : g_last
			assign right_d[i] = '0;
		end else begin : g_right
			assign right_d[i] = data[i+1];
		end

		ffa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (key),
			.cmd     (cell_cmd),
			.tgt     (tgt_q[i]),
			.shl_sel (ge_s2[i]),
			.shr_sel (shr_mask[i]),
			.left    (left_d[i]),
			.right   (right_d[i]),
			.data    (data[i]),
			.flags   (flags[i])
		);
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			fit_v[i]  = flags[i].fit;
			gt_v[i]   = flags[i].gt;
			endm_v[i] = flags[i].endm;
			stm_v[i]  = flags[i].stm;
			vld_v[i]  = data[i].valid;
		end
	end

	// stage 1: register per-cell compares
	always_ff @(posedge clk) begin
		if (state_q == ffa_pkg::S_CMP) begin
			fit_s1  <= fit_v;
			gt_s1   <= gt_v;
			endm_s1 <= endm_v;
			stm_s1  <= stm_v;
			vld_s1  <= vld_v;
		end
	end

	// stage 2: lowest set bit, sentinel at the top marks "past the table"
	// release position is the first start above addr, or the first free cell
	always_comb begin
		if (mode_q == ffa_pkg::MODE_RELEASE) begin
			cand = {1'b1, gt_s1 | ~vld_s1};
		end else begin
			cand = {1'b1, fit_s1};
		end
		cand_m1 = cand - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == ffa_pkg::S_FIND) begin
			koh_s2 <= cand & ~cand_m1;
			ge_s2  <= (~(cand[N-1:0] ^ cand_m1[N-1:0])) | (cand[N-1:0] & ~cand_m1[N-1:0]);
		end
	end

	// ---------------------------------------------------------------- decode
	always_comb begin
		sel_start = '0;
		sel_len   = '0;
		prv_start = '0;
		prv_len   = '0;
		prv_match = 1'b0;
		nxt_match = 1'b0;
		for (int j = 0; j < N; j++) begin
			sel_start = sel_start | ({AW{koh_s2[j]}} & data[j].start);
			sel_len   = sel_len   | ({AW{koh_s2[j]}} & data[j].len);
			prv_start = prv_start | ({AW{koh_s2[j+1]}} & data[j].start);
			prv_len   = prv_len   | ({AW{koh_s2[j+1]}} & data[j].len);
			prv_match = prv_match | (koh_s2[j+1] & endm_s1[j]);
			nxt_match = nxt_match | (koh_s2[j] & vld_s1[j] & stm_s1[j]);
		end
	end

	assign alloc_start = sel_start + size_q;
	assign alloc_len   = sel_len - size_q;
	assign merge_len   = prv_len + size_q + (nxt_match ? sel_len : '0);
	assign full        = (used_q == UW'(N));

	always_comb begin
		dec_cmd        = '0;
		dec_tgt        = '0;
		dec_granted    = '0;
		dec_ctl        = '0;
		dec_ctl.status = ffa_pkg::ST_OK;
		if (mode_q == ffa_pkg::MODE_ALLOC) begin
			if (koh_s2[N]) begin
				dec_ctl.status = ffa_pkg::ST_NOFIT;
			end else begin
				dec_granted = sel_start;
				dec_ctl.sub = 1'b1;
				if (alloc_len == '0) begin
					// region used up: close the gap
					dec_cmd.shl = 1'b1;
					dec_ctl.dec = 1'b1;
				end else begin
					dec_cmd.load  = 1'b1;
					dec_cmd.start = alloc_start;
					dec_cmd.len   = alloc_len;
					dec_tgt       = koh_s2[N-1:0];
				end
			end
		end else if (prv_match) begin
			// grow the preceding region; absorb the following one too if it is adjacent
			dec_cmd.load  = 1'b1;
			dec_cmd.start = prv_start;
			dec_cmd.len   = merge_len;
			dec_tgt       = koh_s2[N:1];
			dec_ctl.add   = 1'b1;
			if (nxt_match) begin
				dec_cmd.shl = 1'b1;
				dec_ctl.dec = 1'b1;
			end
		end else if (nxt_match) begin
			dec_cmd.load  = 1'b1;
			dec_cmd.start = addr_q;
			dec_cmd.len   = sel_len + size_q;
			dec_tgt       = koh_s2[N-1:0];
			dec_ctl.add   = 1'b1;
		end else if (!full) begin
			dec_cmd.load  = 1'b1;
			dec_cmd.shr   = 1'b1;
			dec_cmd.start = addr_q;
			dec_cmd.len   = size_q;
			dec_tgt       = koh_s2[N-1:0];
			dec_ctl.add   = 1'b1;
			dec_ctl.inc   = 1'b1;
		end else begin
			dec_ctl.status = ffa_pkg::ST_LOST;
			dec_ctl.drop   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			ctl_q <= '0;
		end else if (state_q == ffa_pkg::S_DEC) begin
			cmd_q <= dec_cmd;
			ctl_q <= dec_ctl;
		end else if (upd_go) begin
			cmd_q <= '0;
			ctl_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ffa_pkg::S_DEC) begin
			tgt_q     <= dec_tgt;
			granted_q <= dec_granted;
		end
	end

	// ---------------------------------------------------------------- bookkeeping
	assign used_nx    = used_q + UW'(ctl_q.inc) - UW'(ctl_q.dec);
	assign lost_b_sum = {1'b0, lost_b_q} + {1'b0, size_q};

	always_comb begin
		total_nx = total_q;
		if (ctl_q.add) begin
			total_nx = total_q + size_q;
		end else if (ctl_q.sub) begin
			total_nx = total_q - size_q;
		end
		lost_cnt_nx = lost_cnt_q;
		lost_b_nx   = lost_b_q;
		if (ctl_q.drop) begin
			if (lost_cnt_q != '1) begin
				lost_cnt_nx = lost_cnt_q + 1'b1;
			end
			lost_b_nx = lost_b_sum[AW] ? '1 : lost_b_sum[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			peak_q     <= '0;
			total_q    <= '0;
			lost_cnt_q <= '0;
			lost_b_q   <= '0;
		end else if (upd_go) begin
			used_q     <= used_nx;
			peak_q     <= (used_nx > peak_q) ? used_nx : peak_q;
			total_q    <= total_nx;
			lost_cnt_q <= lost_cnt_nx;
			lost_b_q   <= lost_b_nx;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_status_q   <= ctl_q.status;
			out_granted_q  <= granted_q;
			out_total_q    <= total_nx;
			out_count_q    <= CW'(used_nx);
			out_peak_q     <= CW'((used_nx > peak_q) ? used_nx : peak_q);
			out_lost_cnt_q <= lost_cnt_nx;
			out_lost_b_q   <= lost_b_nx;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign granted_addr = out_granted_q;
	assign total_free   = out_total_q;
	assign entry_count  = out_count_q;
	assign peak_entries = out_peak_q;
	assign lost_count   = out_lost_cnt_q;
	assign lost_bytes   = out_lost_b_q;

endmodule

@@ hdl/ffa_checker.sv @@
// ffa_port_props: port-level assertions for the first-fit free list allocator
// depends on ffa_pkg; bound to first_fit_free_list_allocator below

module ffa_port_props #(
	parameter int TABLE_ENTRIES = ffa_pkg::TABLE_ENTRIES_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       mode,
	input logic [ffa_pkg::ADDR_W-1:0] region_addr,
	input logic [ffa_pkg::ADDR_W-1:0] region_size,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [1:0]                 status,
	input logic [ffa_pkg::ADDR_W-1:0] granted_addr,
	input logic [ffa_pkg::ADDR_W-1:0] total_free,
	input logic [ffa_pkg::CNT_W-1:0]  entry_count,
	input logic [ffa_pkg::CNT_W-1:0]  peak_entries,
	input logic [ffa_pkg::ADDR_W-1:0] lost_count,
	input logic [ffa_pkg::ADDR_W-1:0] lost_bytes
);

	// one word in flight: no second accept right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// failed or lost operations never grant an address
	a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ffa_pkg::ST_NOFIT || status == ffa_pkg::ST_LOST)
		|-> granted_addr == '0)
		else $error("nonzero address on failed operation");

	// a lost release only happens with a full table
	a_lost_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ffa_pkg::ST_LOST && TABLE_ENTRIES < 128
		|-> entry_count == ffa_pkg::CNT_W'(TABLE_ENTRIES) && lost_count != '0)
		else $error("release lost with room in the table");

	// peak never below current count
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && TABLE_ENTRIES < 128 |-> entry_count <= peak_entries)
		else $error("entry count above peak");

	// status, granted address and total free hold while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_addr)
		&& $stable(total_free))
		else $error("result changed while stalled");

endmodule

bind first_fit_free_list_allocator ffa_port_props #(.TABLE_ENTRIES(TABLE_ENTRIES))
	u_ffa_port_props (.*);
